FILE: hdl/bqc_pkg.sv
package bqc_pkg;

  localparam int COEF_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W = 4;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2,
    REG_CASCADE
  } reg_idx_t;

  typedef enum logic [2:0] {
    SRC_X,
    SRC_XD1,
    SRC_XD2,
    SRC_YD1,
    SRC_YD2
  } src_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     stage;
    src_t     src;
    reg_idx_t coef;
    acc_op_t  acc;
    logic     fin;
    logic     last;
  } ctl_t;

  localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(14);

  function automatic ctl_t cw(input logic stage, input src_t src, input reg_idx_t coef,
                              input acc_op_t acc, input logic fin, input logic last);
    ctl_t c;
    c.stage = stage;
    c.src   = src;
    c.coef  = coef;
    c.acc   = acc;
    c.fin   = fin;
    c.last  = last;
    return c;
  endfunction

  // The program: five products per stage through one multiplier, then a
  // round-and-saturate step; the second stage is skipped unless cascaded.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    case (step)
      4'd0:    c = cw(1'b0, SRC_X,   REG_B0, ACC_HOLD, 1'b0, 1'b0);
      4'd1:    c = cw(1'b0, SRC_XD1, REG_B1, ACC_LOAD, 1'b0, 1'b0);
      4'd2:    c = cw(1'b0, SRC_XD2, REG_B2, ACC_ADD,  1'b0, 1'b0);
      4'd3:    c = cw(1'b0, SRC_YD1, REG_A1, ACC_ADD,  1'b0, 1'b0);
      4'd4:    c = cw(1'b0, SRC_YD2, REG_A2, ACC_SUB,  1'b0, 1'b0);
      4'd5:    c = cw(1'b0, SRC_X,   REG_B0, ACC_SUB,  1'b0, 1'b0);
      4'd6:    c = cw(1'b0, SRC_X,   REG_B0, ACC_HOLD, 1'b1, 1'b0);
      4'd7:    c = cw(1'b1, SRC_X,   REG_B0, ACC_HOLD, 1'b0, 1'b0);
      4'd8:    c = cw(1'b1, SRC_XD1, REG_B1, ACC_LOAD, 1'b0, 1'b0);
      4'd9:    c = cw(1'b1, SRC_XD2, REG_B2, ACC_ADD,  1'b0, 1'b0);
      4'd10:   c = cw(1'b1, SRC_YD1, REG_A1, ACC_ADD,  1'b0, 1'b0);
      4'd11:   c = cw(1'b1, SRC_YD2, REG_A2, ACC_SUB,  1'b0, 1'b0);
      4'd12:   c = cw(1'b1, SRC_X,   REG_B0, ACC_SUB,  1'b0, 1'b0);
      4'd13:   c = cw(1'b1, SRC_X,   REG_B0, ACC_HOLD, 1'b1, 1'b0);
      4'd14:   c = cw(1'b0, SRC_X,   REG_B0, ACC_HOLD, 1'b0, 1'b1);
      default: c = cw(1'b0, SRC_X,   REG_B0, ACC_HOLD, 1'b0, 1'b1);
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/biquad_filter_optional_cascade.sv
// Direct form I biquad with an optional second stage sharing the coefficients.
// A sample beat is taken only while the block is idle; a short microcode
// program then drives one shared multiplier and an accumulator, one control
// word per cycle. Each stage spends one step filling the product register,
// five multiply-accumulate steps and one round-and-saturate step, and a final
// step loads the output register; that step waits while the output register
// still holds an untaken result. The block takes the next sample only once the
// result is loaded, so it never works on two samples at once. The result sits in
// its own register, so the next sample is accepted while it waits to be taken.
module biquad_filter_optional_cascade
  import bqc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_W-1:0]              cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clipped
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = (PROD_W + 3 > COEF_FRAC_BITS + 2) ? PROD_W + 3 : COEF_FRAC_BITS + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(64'(1) << COEF_FRAC_BITS);

  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic                     cascade;

  logic                    busy;
  logic [STEP_W-1:0]       step;
  ctl_t                    ctl;

  logic signed [SAMPLE_WIDTH-1:0] cur;
  logic signed [SAMPLE_WIDTH-1:0] xd1 [2];
  logic signed [SAMPLE_WIDTH-1:0] xd2 [2];
  logic signed [SAMPLE_WIDTH-1:0] yd1 [2];
  logic signed [SAMPLE_WIDTH-1:0] yd2 [2];
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic                           clip;

  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [COEF_W-1:0]       mul_c;
  logic signed [ACC_W-1:0]        rsum;
  logic signed [ACC_W-1:0]        yfull;
  logic signed [SAMPLE_WIDTH-1:0] ysat;
  logic                           ysat_clip;

  assign ctl       = ucode(step);
  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;

  always_comb begin
    case (ctl.src)
      SRC_X:   mul_a = cur;
      SRC_XD1: mul_a = xd1[ctl.stage];
      SRC_XD2: mul_a = xd2[ctl.stage];
      SRC_YD1: mul_a = yd1[ctl.stage];
      SRC_YD2: mul_a = yd2[ctl.stage];
      default: mul_a = cur;
    endcase
    case (ctl.coef)
      REG_B0:  mul_c = coef_b0;
      REG_B1:  mul_c = coef_b1;
      REG_B2:  mul_c = coef_b2;
      REG_A1:  mul_c = coef_a1;
      REG_A2:  mul_c = coef_a2;
      default: mul_c = coef_b0;
    endcase
  end

  always_comb begin
    rsum  = acc + HALF;
    yfull = rsum >>> COEF_FRAC_BITS;
    if (yfull > SMAX) begin
      ysat      = SMAX[SAMPLE_WIDTH-1:0];
      ysat_clip = 1'b1;
    end else if (yfull < SMIN) begin
      ysat      = SMIN[SAMPLE_WIDTH-1:0];
      ysat_clip = 1'b1;
    end else begin
      ysat      = yfull[SAMPLE_WIDTH-1:0];
      ysat_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= B0_RESET;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
      cascade <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_B0:      coef_b0 <= cfg_data;
        REG_B1:      coef_b1 <= cfg_data;
        REG_B2:      coef_b2 <= cfg_data;
        REG_A1:      coef_a1 <= cfg_data;
        REG_A2:      coef_a2 <= cfg_data;
        REG_CASCADE: cascade <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_c;
    case (ctl.acc)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      ACC_SUB:  acc <= acc - ACC_W'(prod);
      default:  acc <= acc;
    endcase
    if (in_valid && in_ready) begin
      cur <= sample_in;
    end else if (busy && ctl.fin) begin
      cur <= ysat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        xd1[s] <= '0;
        xd2[s] <= '0;
        yd1[s] <= '0;
        yd2[s] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !(busy && ctl.last)) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        step <= '0;
        clip <= 1'b0;
      end else if (busy) begin
        if (ctl.last) begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            sample_out <= cur;
            clipped    <= clip;
            busy       <= 1'b0;
          end
        end else if (ctl.fin) begin
          xd2[ctl.stage] <= xd1[ctl.stage];
          xd1[ctl.stage] <= cur;
          yd2[ctl.stage] <= yd1[ctl.stage];
          yd1[ctl.stage] <= ysat;
          clip           <= clip | ysat_clip;
          step           <= (!ctl.stage && !cascade) ? STEP_DONE : step + STEP_W'(1);
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

`ifndef SYNTH
  a_start_at_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> busy && step == '0)
    else $error("sample accepted but program did not start at its first step");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= STEP_DONE)
    else $error("step counter ran past the end of the program");

  a_skip_second: assert property (@(posedge clk) disable iff (rst)
    busy && ctl.fin && !ctl.stage && !cascade |=> busy && step == STEP_DONE)
    else $error("second stage not skipped with cascade disabled");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    busy && ctl.last && out_valid && !out_ready |=> busy && step == STEP_DONE)
    else $error("result dropped while the output register was full");
`endif

endmodule

FILE: sim/bqc_checker.sv
`timescale 1ns / 100ps

module bqc_checker
  import bqc_pkg::*;
#(
  parameter int SW   = SAMPLE_WIDTH_DEF,
  parameter int FRAC = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [SW-1:0] sample_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [SW-1:0] sample_out,
  input  logic                 clipped,
  output int                   fail_count,
  output int                   pending,
  output int                   samples_done,
  output int                   clip_count,
  output int                   cascade_count
);

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          clip;
  } filt_result_t;

  logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
  logic                     cascade_on;
  logic signed [SW-1:0]     xd1 [2];
  logic signed [SW-1:0]     xd2 [2];
  logic signed [SW-1:0]     yd1 [2];
  logic signed [SW-1:0]     yd2 [2];
  filt_result_t             expected_q [$];

  function automatic logic signed [SW-1:0] run_section(input int s,
                                                       input logic signed [SW-1:0] x,
                                                       inout logic clip);
    longint acc;
    longint y;
    acc = longint'(b0) * longint'(x) + longint'(b1) * longint'(xd1[s])
        + longint'(b2) * longint'(xd2[s]) - longint'(a1) * longint'(yd1[s])
        - longint'(a2) * longint'(yd2[s]);
    y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
      clip = 1'b1;
    end else if (y < SAMPLE_MIN) begin
      y = SAMPLE_MIN;
      clip = 1'b1;
    end
    xd2[s] = xd1[s];
    xd1[s] = x;
    yd2[s] = yd1[s];
    yd1[s] = SW'(y);
    return SW'(y);
  endfunction

  function automatic filt_result_t filter_sample(input logic signed [SW-1:0] x);
    filt_result_t         r;
    logic                 clip;
    logic signed [SW-1:0] y;
    clip = 1'b0;
    y = run_section(0, x, clip);
    if (cascade_on) y = run_section(1, y, clip);
    r.sample = y;
    r.clip   = clip;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    filt_result_t want;
    int           fails;
    fails = 0;
    if (rst) begin
      b0         = COEF_W'(1) << FRAC;
      b1         = '0;
      b2         = '0;
      a1         = '0;
      a2         = '0;
      cascade_on = 1'b0;
      for (int s = 0; s < 2; s++) begin
        xd1[s] = '0;
        xd2[s] = '0;
        yd1[s] = '0;
        yd2[s] = '0;
      end
      expected_q.delete();
      fail_count    <= 0;
      pending       <= 0;
      samples_done  <= 0;
      clip_count    <= 0;
      cascade_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_B0:      b0 = cfg_data;
          REG_B1:      b1 = cfg_data;
          REG_B2:      b2 = cfg_data;
          REG_A1:      a1 = cfg_data;
          REG_A2:      a2 = cfg_data;
          REG_CASCADE: cascade_on = cfg_data[0];
          default:     ;
        endcase
      end
      // The output beat is matched before this edge's input beat is predicted.
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: output beat with nothing expected, got sample %0d clipped %0b",
                   $time, sample_out, clipped);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (sample_out !== want.sample) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, $signed(want.sample), sample_out);
            fails++;
          end
          if (clipped !== want.clip) begin
            $display("%0t: clipped mismatch, expected %0b, got %0b",
                     $time, want.clip, clipped);
            fails++;
          end
        end
        samples_done <= samples_done + 1;
      end
      if (in_valid && in_ready) begin
        want = filter_sample(sample_in);
        expected_q.push_back(want);
        if (want.clip) clip_count <= clip_count + 1;
        if (cascade_on) cascade_count <= cascade_count + 1;
      end
      fail_count <= fail_count + fails;
      pending    <= expected_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bqc_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
  localparam int COEF_MAX = 131071;
  localparam int COEF_MIN = -131072;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int LONG_STALL = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] sample_out;
  logic                 clipped;

  int fail_count, pending, samples_done, clip_count, cascade_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int coef_sets = 0;

  biquad_filter_optional_cascade dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  bqc_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .clipped       (clipped),
    .fail_count    (fail_count),
    .pending       (pending),
    .samples_done  (samples_done),
    .clip_count    (clip_count),
    .cascade_count (cascade_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // The receiver holds off once for a long stretch so that the block backs up
  // into its input while the sender keeps offering beats.
  initial begin : sink
    bit long_stall_done;
    long_stall_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_stall_done && samples_done >= 60) begin
        long_stall_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_sample(input logic [SW-1:0] x);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_filter(input int c_b0, input int c_b1, input int c_b2,
                             input int c_a1, input int c_a2,
                             input logic [COEF_W-1:0] cascade_word);
    write_reg(REG_B0, COEF_W'(c_b0));
    write_reg(REG_B1, COEF_W'(c_b1));
    write_reg(REG_B2, COEF_W'(c_b2));
    write_reg(REG_A1, COEF_W'(c_a1));
    write_reg(REG_A2, COEF_W'(c_a2));
    write_reg(REG_CASCADE, cascade_word);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, COEF_W'($urandom));
    cfg_valid <= 1'b0;
    coef_sets++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 2))
      0:       return COEF_MIN;
      1:       return 0;
      default: return COEF_MAX;
    endcase
  endfunction

  task automatic random_filter(input int kind);
    int                lim;
    int                c_a2;
    logic [COEF_W-1:0] cascade_word;
    cascade_word    = COEF_W'($urandom);
    cascade_word[0] = 1'($urandom_range(0, 1));
    case (kind)
      0: load_filter($urandom, $urandom, $urandom, $urandom, $urandom, cascade_word);
      1: load_filter(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                     pick_extreme(), cascade_word);
      2: begin
        c_a2 = $urandom_range(0, 13000);
        lim  = (16384 + c_a2) * 9 / 10;
        load_filter(int'($urandom_range(0, 8192)) - 4096, int'($urandom_range(0, 8192)) - 4096,
                    int'($urandom_range(0, 8192)) - 4096, int'($urandom_range(0, 2 * lim)) - lim,
                    c_a2, cascade_word);
      end
      default: load_filter(int'($urandom_range(0, 65536)) - 32768, 0, 0, 0, 0, cascade_word);
    endcase
  endtask

  function automatic logic [SW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? SW'(32767) : SW'(-32768);
      1, 2, 3: return SW'(int'($urandom_range(0, 512)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int done_items;
    int seg;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 74;

    // Reset coefficients pass the input straight through.
    send_sample(SW'(32767));
    send_sample(SW'(-32768));
    send_sample(SW'(0));
    send_sample(SW'(-1));
    send_sample(SW'(1));
    send_sample(SW'(16'h5555));
    send_sample(SW'(16'hAAAA));
    drain();

    load_filter(COEF_MAX, COEF_MIN, 0, 0, 0, COEF_W'(0));
    send_sample(SW'(32767));
    send_sample(SW'(-32768));
    send_sample(SW'(100));
    send_sample(SW'(-100));
    drain();

    write_reg(REG_SPARE_LO, COEF_W'(18'h3FFFF));
    write_reg(REG_SPARE_HI, COEF_W'(18'h15555));
    load_filter(2048, 4096, 2048, -24000, 9000, COEF_W'(18'h2AAAB));
    repeat (4) send_sample(SW'(32767));
    repeat (2) send_sample(SW'(-32768));
    drain();

    // Switching the second stage off and on again must leave its history intact.
    load_filter(2048, 4096, 2048, -24000, 9000, COEF_W'(18'h3FFFE));
    send_sample(SW'(1000));
    send_sample(SW'(-1000));
    send_sample(SW'(0));
    drain();
    load_filter(2048, 4096, 2048, -24000, 9000, COEF_W'(18'h00001));
    send_sample(SW'(20000));
    send_sample(SW'(-20000));
    send_sample(SW'(5));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      done_items = 0;
      while (done_items < RANDOM_PER_PHASE) begin
        drain();
        random_filter(done_items == 0 ? 1 : $urandom_range(0, 3));
        seg = $urandom_range(10, 40);
        repeat (seg) send_sample(random_sample());
        done_items += seg;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb: %0d samples filtered, %0d through both stages, %0d saturated",
             samples_done, cascade_count, clip_count);
    $display("tb: %0d coefficient sets loaded, one long output stall applied", coef_sets);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
